[hdl/rcfm_pkg.sv]
// ============================================================================
// rcfm_pkg: shared definitions for the RMS current and fan over-limit monitor
// Widths, scale factors, register indexes, reset values and the command and
// status bundles that pass between the controller and the datapath.
// ============================================================================
package rcfm_pkg;

    // Default full-scale resolution of the converter codes.
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed payload and state widths.
    localparam int CONV_W  = 15;   // converted mA or rpm value
    localparam int SQ_W    = 2 * CONV_W;
    localparam int SUM_W   = 39;   // saturating sum of squares
    localparam int COUNT_W = 10;   // sample counter and window length
    localparam int DIV_W   = COUNT_W + 1;  // divisor holds up to 1024
    localparam int ROOT_W  = (SUM_W + 1) / 2;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int LIMIT_W = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int STEP_W  = $clog2(SUM_W);

    // Conversion factors: mA and rpm per full-scale code.
    localparam logic [CONV_W-1:0] CUR_SCALE = 15'd16500;
    localparam logic [CONV_W-1:0] FAN_SCALE = 15'd1650;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_CURRENT_LIMIT = 2'd1;
    localparam logic [IDX_W-1:0] REG_FAN_LIMIT     = 2'd2;

    // Register reset values.
    localparam logic [COUNT_W-1:0] WINDOW_RESET    = 10'd1000;
    localparam logic [LIMIT_W-1:0] CUR_LIMIT_RESET = 16'd15000;
    localparam logic [LIMIT_W-1:0] FAN_LIMIT_RESET = 16'd1500;

    // Sample and result kind codes.
    localparam logic KIND_CURRENT = 1'b0;
    localparam logic KIND_FAN     = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture an accepted input word
        logic convert;    // scale the code to mA or rpm
        logic square;     // square the mA value
        logic accum;      // add the square and count the sample
        logic div_init;   // start the window divide, clear the sum
        logic div_step;   // one restoring divide step
        logic sqrt_init;  // start the square root
        logic sqrt_step;  // one square root digit
        logic out_load;   // move the result into the output register
    } rcfm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_fan;      // current word is a fan sample
        logic window_hit;  // this current sample closes the window
        logic out_free;    // output register can take a result now
    } rcfm_status_t;

endpackage

[hdl/rcfm_ctrl.sv]
// ============================================================================
// rcfm_ctrl: sequencing controller
// Walks each accepted word through conversion, accumulation and, at the end
// of a window, the iterative divide and square root, then hands the result
// to the output register.
// ============================================================================
module rcfm_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  rcfm_pkg::rcfm_status_t  status,
    output rcfm_pkg::rcfm_cmd_t     ctrl
);
    import rcfm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_SQRT_INIT,
        ST_SQRT_STEP,
        ST_EMIT
    } state_t;

    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                ctrl.convert = 1'b1;
                state_next   = status.is_fan ? ST_EMIT : ST_SQUARE;
            end
            ST_SQUARE:
            begin
                ctrl.square = 1'b1;
                state_next  = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                ctrl.accum = 1'b1;
                state_next = status.window_hit ? ST_DIV_INIT : ST_IDLE;
            end
            ST_DIV_INIT:
            begin
                ctrl.div_init = 1'b1;
                step_next     = '0;
                state_next    = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                ctrl.div_step = 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_SQRT_INIT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_SQRT_INIT:
            begin
                ctrl.sqrt_init = 1'b1;
                step_next      = '0;
                state_next     = ST_SQRT_STEP;
            end
            ST_SQRT_STEP:
            begin
                ctrl.sqrt_step = 1'b1;
                if (step_reg == SQRT_LAST)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // An accepted word always starts with its conversion.
    a_accept_converts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_CONVERT)
        else $error("accepted word did not enter conversion");

    // The divide runs exactly its full bit count before the root starts.
    a_div_to_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_STEP && step_reg == DIV_LAST |=> state_reg == ST_SQRT_INIT)
        else $error("divide did not hand over to the square root");

endmodule

[hdl/rcfm_datapath.sv]
// ============================================================================
// rcfm_datapath: conversion, accumulation, divide, square root and output
// Holds the configuration registers, the running sum of squares, a shared
// shift register for the bit-serial divide and square root, and the output
// register that separates the result from the receiver.
// ============================================================================
module rcfm_datapath #(
    parameter int SAMPLE_BITS = rcfm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [rcfm_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rcfm_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          cmd,
    input  logic [SAMPLE_BITS-1:0]        adc_code,
    input  rcfm_pkg::rcfm_cmd_t           ctrl,
    output rcfm_pkg::rcfm_status_t        status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output logic [rcfm_pkg::CONV_W-1:0]   value,
    output logic                          alert
);
    import rcfm_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + CONV_W;

    // Configuration and control state.
    logic [COUNT_W-1:0]  window_reg,    window_next;
    logic [LIMIT_W-1:0]  cur_limit_reg, cur_limit_next;
    logic [LIMIT_W-1:0]  fan_limit_reg, fan_limit_next;
    logic [SUM_W-1:0]    sum_reg,       sum_next;
    logic [COUNT_W-1:0]  count_reg,     count_next;
    logic                out_valid_reg, out_valid_next;

    // Payload state.
    logic                kind_reg,      kind_next;
    logic [SAMPLE_BITS-1:0] code_reg,   code_next;
    logic [CONV_W-1:0]   conv_reg,      conv_next;
    logic [SQ_W-1:0]     sq_reg,        sq_next;
    logic [RAD_W-1:0]    work_reg,      work_next;
    logic [REM_W-1:0]    rem_reg,       rem_next;
    logic [ROOT_W-1:0]   root_reg,      root_next;
    logic                out_kind_reg,  out_kind_next;
    logic [CONV_W-1:0]   out_value_reg, out_value_next;
    logic                out_alert_reg, out_alert_next;

    // Arithmetic.
    logic [PROD_W-1:0]   product;
    logic [CONV_W-1:0]   scale;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_add;
    logic [COUNT_W-1:0]  count_inc;
    logic [DIV_W-1:0]    divisor;
    logic [DIV_W:0]      div_trial;
    logic [DIV_W:0]      div_diff;
    logic                div_ge;
    logic [REM_W-1:0]    sqrt_shift;
    logic [REM_W-1:0]    sqrt_trial;
    logic                sqrt_ge;
    logic [CONV_W-1:0]   root_sat;

    always_comb
    begin
        scale    = (kind_reg == KIND_FAN) ? FAN_SCALE : CUR_SCALE;
        product  = PROD_W'(code_reg) * PROD_W'(scale);
        sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);
        sum_add  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        count_inc = count_reg + COUNT_W'(1);

        // A window length of zero divides by 1024, one past the counter range.
        divisor   = {window_reg == '0, window_reg};
        div_trial = {rem_reg[DIV_W-1:0], work_reg[SUM_W-1]};
        div_ge    = div_trial >= {1'b0, divisor};
        div_diff  = div_trial - {1'b0, divisor};

        sqrt_shift = {rem_reg[REM_W-3:0], work_reg[RAD_W-1:RAD_W-2]};
        sqrt_trial = {root_reg, 2'b01};
        sqrt_ge    = sqrt_shift >= sqrt_trial;

        root_sat = (root_reg[ROOT_W-1:CONV_W] != '0) ? '1 : root_reg[CONV_W-1:0];
    end

    assign status.is_fan     = (kind_reg == KIND_FAN);
    assign status.window_hit = (count_inc == window_reg);
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        window_next    = window_reg;
        cur_limit_next = cur_limit_reg;
        fan_limit_next = fan_limit_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        code_next      = code_reg;
        conv_next      = conv_reg;
        sq_next        = sq_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_alert_next = out_alert_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH: window_next    = cfg_data[COUNT_W-1:0];
                REG_CURRENT_LIMIT: cur_limit_next = cfg_data[LIMIT_W-1:0];
                REG_FAN_LIMIT:     fan_limit_next = cfg_data[LIMIT_W-1:0];
                default:           window_next    = window_reg;
            endcase
        end

        if (ctrl.load)
        begin
            kind_next = cmd;
            code_next = adc_code;
        end
        if (ctrl.convert)
        begin
            conv_next = product[SAMPLE_BITS +: CONV_W];
        end
        if (ctrl.square)
        begin
            sq_next = SQ_W'(conv_reg) * SQ_W'(conv_reg);
        end
        if (ctrl.accum)
        begin
            sum_next   = sum_add;
            count_next = count_inc;
        end
        if (ctrl.div_init)
        begin
            work_next  = {1'b0, sum_reg};
            rem_next   = '0;
            sum_next   = '0;
            count_next = '0;
        end
        if (ctrl.div_step)
        begin
            work_next = {1'b0, work_reg[SUM_W-2:0], div_ge};
            rem_next  = REM_W'(div_ge ? div_diff[DIV_W-1:0] : div_trial[DIV_W-1:0]);
        end
        if (ctrl.sqrt_init)
        begin
            rem_next  = '0;
            root_next = '0;
        end
        if (ctrl.sqrt_step)
        begin
            work_next = {work_reg[RAD_W-3:0], 2'b00};
            rem_next  = sqrt_ge ? (sqrt_shift - sqrt_trial) : sqrt_shift;
            root_next = {root_reg[ROOT_W-2:0], sqrt_ge};
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = kind_reg;
            if (kind_reg == KIND_FAN)
            begin
                out_value_next = conv_reg;
                out_alert_next = LIMIT_W'(conv_reg) >= fan_limit_reg;
            end
            else
            begin
                out_value_next = root_sat;
                // The limit compares against the root before saturation.
                out_alert_next = root_reg >= ROOT_W'(cur_limit_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            cur_limit_reg <= CUR_LIMIT_RESET;
            fan_limit_reg <= FAN_LIMIT_RESET;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            cur_limit_reg <= cur_limit_next;
            fan_limit_reg <= fan_limit_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        code_reg      <= code_next;
        conv_reg      <= conv_next;
        sq_reg        <= sq_next;
        work_reg      <= work_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_alert_reg <= out_alert_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign value     = out_value_reg;
    assign alert     = out_alert_reg;

    // The divide remainder always stays below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_step |=> rem_reg < REM_W'(divisor))
        else $error("divide remainder reached the divisor");

    // The root remainder never exceeds twice the partial root.
    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.sqrt_step |=> rem_reg <= {1'b0, root_reg, 1'b0})
        else $error("square root remainder out of range");

endmodule

[hdl/rms_current_and_fan_overlimit_monitor_top.sv]
// ============================================================================
// rms_current_and_fan_overlimit_monitor_top: windowed RMS and fan monitor
// Converts tagged converter codes to mA or rpm, reports fan speed at once
// and RMS current once per window, each with an over-limit alert.
// ============================================================================
// Usage
// The input channel carries one word per sample: cmd selects a current
// sample (0) or a fan speed sample (1), adc_code holds the raw code. A word
// is taken at a rising edge where in_valid is high and in_stall is low.
// The output channel presents kind, value and alert under out_valid; the
// receiver holds out_stall high to keep a word waiting.
// A fan word is converted and then handed to the output register. A current
// word that does not close a window is converted, squared and added to the
// sum of squares, and produces nothing.
// A current word that closes a window runs a bit-serial divide (one bit per
// cycle over the 39-bit sum) and a bit-serial square root (one root bit per
// cycle, 20 bits) before its result goes to the output register.
// The output register lets a new word enter while a result waits. Input is
// held back while a word is in work, also while a finished result finds the
// output register stalled, until the receiver takes the waiting word.
// Reset clears the sum, the sample count and the output valid flag, and
// loads the window length of 1000 and the limits of 15000 mA and 1500 rpm.
// Configuration writes are taken whenever cfg_wr_en is high.
// ============================================================================
module rms_current_and_fan_overlimit_monitor_top #(
    parameter int SAMPLE_BITS = rcfm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [rcfm_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rcfm_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [SAMPLE_BITS-1:0]        adc_code,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output logic [rcfm_pkg::CONV_W-1:0]   value,
    output logic                          alert
);
    import rcfm_pkg::*;

    // Commands and status between the sequencer and the arithmetic.
    rcfm_cmd_t    ctrl;
    rcfm_status_t status;

    // The controller owns the input handshake and the step counting.
    rcfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .ctrl     (ctrl)
    );

    // The datapath owns the registers, the arithmetic and the output word.
    rcfm_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .adc_code  (adc_code),
        .ctrl      (ctrl),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .value     (value),
        .alert     (alert)
    );

endmodule
